### design/lbm_pkg.sv
package lbm_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned MAX_BLOCK  = 128;
  localparam int unsigned LED_COUNT  = 10;

  localparam int unsigned CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W      = SAMPLE_W + $clog2(MAX_BLOCK);

  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned ACC_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);

  // mean / 2^31 in Q0.16 is (sum >> 15) / count
  localparam int unsigned Q_SHIFT    = SAMPLE_W - LEVEL_W - 1;
  localparam int unsigned DIVD_W     = SUM_W - Q_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVD_W);

  localparam int unsigned N_W        = $clog2(LED_COUNT + 1);
  localparam int unsigned SQ_W       = $clog2(LED_COUNT * LED_COUNT + 1);
  localparam int unsigned LIM_W      = LEVEL_W + SQ_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

  localparam int unsigned OUT_W      = LEVEL_W + LED_COUNT + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctl_t;

endpackage

### design/lbm_accum.sv
module lbm_accum import lbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acc_ctl_t            ctl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SUM_W-1:0]    sum_o,
  output logic [CNT_W-1:0]    count_o,
  output logic                too_long_o,
  output logic                done_o
);

  logic [ACC_W-1:0]     sum_q;
  logic [ACC_W-1:0]     op_q;
  logic                 carry_q;
  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIG_CNT_W-1:0] dig_q;

  logic                 full;
  logic                 neg;
  logic [ACC_W-1:0]     sext;
  logic [DIGIT_W:0]     dsum;

  assign full = (count_q == CNT_W'(MAX_BLOCK));
  assign neg  = sample_i[SAMPLE_W-1];
  assign sext = {{(ACC_W - SAMPLE_W){neg}}, sample_i};
  // one digit of sum + |sample| per cycle; negation is invert plus carry-in
  assign dsum = {1'b0, sum_q[DIGIT_W-1:0]} + {1'b0, op_q[DIGIT_W-1:0]}
              + {{DIGIT_W{1'b0}}, carry_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      dig_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.clear) begin
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        dig_q  <= '0;
        if (full) begin
          ovf_q   <= 1'b1;
          op_q    <= '0;
          carry_q <= 1'b0;
        end else begin
          count_q <= count_q + 1'b1;
          op_q    <= sext ^ {ACC_W{neg}};
          carry_q <= neg;
        end
      end else if (busy_q) begin
        sum_q   <= {dsum[DIGIT_W-1:0], sum_q[ACC_W-1:DIGIT_W]};
        op_q    <= op_q >> DIGIT_W;
        carry_q <= dsum[DIGIT_W];
        dig_q   <= dig_q + 1'b1;
        if (dig_q == DIG_CNT_W'(NUM_DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sum_o      = sum_q[SUM_W-1:0];
  assign count_o    = count_q;
  assign too_long_o = ovf_q;
  assign done_o     = done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCK))
    else $error("sample count beyond block limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set with block not full");

endmodule

### design/lbm_div.sv
module lbm_div import lbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIVD_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic [LEVEL_W-1:0] level_o,
  output logic               done_o
);

  logic [DIVD_W-1:0]    div_q;
  logic [DIVD_W-1:0]    quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic                 busy_q;
  logic                 done_q;

  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;
  logic                 sat;

  assign trial = {rem_q, div_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
        div_q  <= dividend_i;
        den_q  <= count_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_q  <= {quo_q[DIVD_W-2:0], ge};
        div_q  <= div_q << 1;
        step_q <= step_q + 1'b1;
        if (step_q == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sat     = |quo_q[DIVD_W-1:LEVEL_W];
  assign level_o = (den_q == '0) ? '0 : (sat ? '1 : quo_q[LEVEL_W-1:0]);
  assign done_o  = done_q;

endmodule

### design/lbm_bar.sv
module lbm_bar import lbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LEVEL_W-1:0]   level_i,
  output logic [LED_COUNT-1:0] bar_o,
  output logic                 done_o
);

  localparam int unsigned CMP_W = 2 * N_W + LEVEL_W;

  logic [LIM_W-1:0] limit_q;
  logic [N_W-1:0]   n_q;
  logic             busy_q;
  logic             done_q;

  logic [N_W-1:0]   nxt;
  logic [2*N_W-1:0] prod;
  logic [CMP_W-1:0] lim_ext;
  logic             go;

  assign nxt     = n_q + 1'b1;
  assign prod    = (2*N_W)'(nxt) * (2*N_W)'(nxt);
  assign lim_ext = CMP_W'(limit_q);
  assign go      = (n_q < N_W'(LED_COUNT)) && ({prod, {LEVEL_W{1'b0}}} <= lim_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        n_q     <= '0;
        limit_q <= LIM_W'(LIM_W'(level_i) * LIM_W'(LED_COUNT * LED_COUNT));
      end else if (busy_q) begin
        if (go) begin
          n_q <= nxt;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      bar_o[i] = (N_W'(i) < n_q);
    end
  end

  assign done_o = done_q;

endmodule

### design/audio_block_loudness_meter_unit.sv
// Non-final sample: accepted, then ready again after 10 digit-serial add steps.
// Final sample: the result is valid after 10 add steps, 24 restoring divide steps,
// up to 11 bar search steps, plus handoff.
// A finished result waits in the output register while the next block accumulates.
// rst_ni (async, active low) clears the sum, count, flags, output valid and
// loads loud_threshold with 32768.
module audio_block_loudness_meter_unit import lbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [THR_W-1:0]      cfg_wr_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [15:0] level, [25:16] led_bar,
                                                // [26] loud, [27] block_too_long
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_BAR,
    ST_HOLD
  } state_e;

  state_e                state_q;
  logic                  last_q;
  logic [THR_W-1:0]      thr_q;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  acc_ctl_t              acc_ctl;
  logic [SUM_W-1:0]      acc_sum;
  logic [CNT_W-1:0]      acc_count;
  logic                  acc_too_long;
  logic                  acc_done;
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_W-1:0]    level;
  logic                  bar_start;
  logic                  bar_done;
  logic [LED_COUNT-1:0]  led_bar;
  logic                  accept;
  logic                  out_free;
  logic                  load_out;
  logic                  loud;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_out      = (state_q == ST_HOLD) && out_free;
  assign div_start     = (state_q == ST_ACC) && acc_done && last_q;
  assign bar_start     = (state_q == ST_DIV) && div_done;
  assign loud          = (level > thr_q);

  assign acc_ctl.start = accept;
  assign acc_ctl.clear = load_out;

  lbm_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (acc_ctl),
    .sample_i   (s_axis_tdata),
    .sum_o      (acc_sum),
    .count_o    (acc_count),
    .too_long_o (acc_too_long),
    .done_o     (acc_done)
  );

  lbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_sum[SUM_W-1:Q_SHIFT]),
    .count_i    (acc_count),
    .level_o    (level),
    .done_o     (div_done)
  );

  lbm_bar u_bar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bar_start),
    .level_i (level),
    .bar_o   (led_bar),
    .done_o  (bar_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= 1'b0;
      thr_q     <= THR_RESET;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        thr_q <= cfg_wr_data_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q  <= s_axis_tlast;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_done) begin
            state_q <= last_q ? ST_DIV : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_BAR;
          end
        end
        ST_BAR: begin
          if (bar_done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_data_q  <= OUT_DATA_W'({acc_too_long, loud, led_bar, level});
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_acc_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == ST_ACC))
    else $error("accumulator finished outside accumulate phase");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide phase");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("result not presented after load");

endmodule

### bench/audio_block_loudness_meter_unit_tb.sv
module audio_block_loudness_meter_unit_tb;
  import lbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned LONG_HOLD = 600;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  logic [THR_W-1:0]      cfg_wr_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  typedef struct {
    logic [LEVEL_W-1:0]   level;
    logic [LED_COUNT-1:0] led_bar;
    logic                 loud;
    logic                 too_long;
  } meter_result_t;

  class level_scoreboard;
    logic [THR_W-1:0] threshold;
    logic [SUM_W-1:0] abs_sum;
    int unsigned      count;
    bit               too_long;
    meter_result_t    pending_q[$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      threshold = THR_RESET;
      abs_sum = '0;
      count = 0;
      too_long = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, bit last);
      logic [SUM_W-1:0] mag;
      longint unsigned  lvl;
      longint unsigned  lim;
      int unsigned      n;
      meter_result_t    r;
      mag = s[SAMPLE_W-1] ? (SUM_W'(33'h1_0000_0000) - SUM_W'(s)) : SUM_W'(s);
      if (count >= MAX_BLOCK) begin
        too_long = 1;
      end else begin
        abs_sum = abs_sum + mag;
        count++;
      end
      if (!last) return;
      lvl = (count == 0) ? 0 : longint'(abs_sum) / (longint'(count) << Q_SHIFT);
      if (lvl > 65535) lvl = 65535;
      lim = lvl * LED_COUNT * LED_COUNT;
      n = 0;
      while (n < LED_COUNT && longint'((n + 1) * (n + 1)) * 65536 <= lim) n++;
      r.level = lvl[LEVEL_W-1:0];
      r.led_bar = LED_COUNT'((1 << n) - 1);
      r.loud = (lvl > threshold);
      r.too_long = too_long;
      pending_q.push_back(r);
      abs_sum = '0;
      count = 0;
      too_long = 0;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      meter_result_t r;
      if (pending_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", d);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      checked++;
      if (d[LEVEL_W-1:0] !== r.level) begin
        $error("level: expected %0d, actual %0d", r.level, d[LEVEL_W-1:0]);
        errors++;
      end
      if (d[LEVEL_W +: LED_COUNT] !== r.led_bar) begin
        $error("led_bar: expected %b, actual %b", r.led_bar, d[LEVEL_W +: LED_COUNT]);
        errors++;
      end
      if (d[LEVEL_W+LED_COUNT] !== r.loud) begin
        $error("loud: expected %0d, actual %0d", r.loud, d[LEVEL_W+LED_COUNT]);
        errors++;
      end
      if (d[LEVEL_W+LED_COUNT+1] !== r.too_long) begin
        $error("block_too_long: expected %0d, actual %0d", r.too_long,
               d[LEVEL_W+LED_COUNT+1]);
        errors++;
      end
    endfunction
  endclass

  level_scoreboard sb;
  bit              quiet;
  int unsigned     cycles;

  audio_block_loudness_meter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    int unsigned hold_cycles;
    bit          hold_done;
    hold_done = 0;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.checked >= 20) begin
        m_axis_tready <= 0;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(negedge clk_i);
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] d, bit last);
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(d, last);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // drop valid, drain expected results, then let a busy add pass finish
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(negedge clk_i);
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= v;
    @(negedge clk_i);
    cfg_wr_en_i <= 0;
    sb.threshold = v;
  endtask

  function automatic logic [SAMPLE_W-1:0] next_sample(int unsigned shift);
    logic [SAMPLE_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom;
      default: begin
        mag = $urandom >> shift;
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic int unsigned pick_block_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 93) return $urandom_range(7, 40);
    if (r < 97) return $urandom_range(100, MAX_BLOCK);
    return $urandom_range(MAX_BLOCK + 1, MAX_BLOCK + 8);
  endfunction

  task automatic run_blocks(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned shift;
    sent = 0;
    while (sent < n_items) begin
      len = pick_block_len();
      if (len > n_items - sent) len = n_items - sent;
      shift = $urandom_range(0, 20);
      for (int unsigned i = 0; i < len; i++) begin
        if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 17));
        send_sample(next_sample(shift), i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    rst_ni = 0;
    cfg_wr_en_i = 0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;

    // default threshold, extremes and bar boundaries
    send_sample(32'h0000_0000, 1);
    send_sample(32'h8000_0000, 1);
    send_sample(32'h7fff_ffff, 1);
    send_sample(32'h4000_0000, 1);
    send_sample(32'hc000_0000, 1);
    send_sample(32'h4000_8000, 1);
    send_sample(32'hffff_ffff, 0);
    send_sample(32'h0000_0001, 1);
    send_sample(32'h8000_0000, 0);
    send_sample(32'h8000_0000, 0);
    send_sample(32'h8000_0000, 1);
    send_sample(32'h7fff_ffff, 0);
    send_sample(32'h0000_0000, 1);
    send_sample(32'h0000_8000, 1);
    send_sample(32'h0147_8000, 1);
    send_sample(32'h0148_0000, 1);
    wait_idle();
    write_threshold(16'd0);
    send_sample(32'h0000_0000, 1);
    send_sample(32'h0000_8000, 1);
    wait_idle();
    write_threshold(16'hffff);
    send_sample(32'h8000_0000, 1);
    send_sample(32'h7fff_8000, 1);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: write_threshold(THR_W'($urandom_range(0, 65535)));
        1: write_threshold(16'd1);
        2: write_threshold(16'hfffe);
        3: write_threshold(THR_W'($urandom_range(0, 65535)));
        default: begin
          write_threshold(16'd32768);
          quiet = 1;
        end
      endcase
      run_blocks(146);
    end

    wait_idle();
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $error("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
design/lbm_pkg.sv
design/lbm_accum.sv
design/lbm_div.sv
design/lbm_bar.sv
design/audio_block_loudness_meter_unit.sv
bench/audio_block_loudness_meter_unit_tb.sv
